[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros
// Concurrent assertion macros used by the top-level RTL file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, pre, post)
`define ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

[rtl/ffha_pkg.sv]
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared types and constants of the first-fit heap allocator.
// ----------------------------------------------------------------------------
package ffha_pkg;
   localparam int HEAP_UNITS_DEF   = 1024;
   localparam int HEADER_UNITS_DEF = 1;

   typedef enum logic [1:0] {
      OP_ALLOC = 2'd0,
      OP_FREE  = 2'd1,
      OP_QUERY = 2'd2,
      OP_NOP   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_NO_FIT   = 2'd1,
      ST_NO_BLOCK = 2'd2
   } status_type;

   // memory port request from the sequencer
   typedef struct packed {
      logic        rd_en;
      logic        wr_en;
      logic [15:0] rd_addr;
      logic [15:0] wr_addr;
      logic        wr_start;
      logic        wr_free;
      logic [16:0] wr_size;
   } mem_req_type;

   typedef struct packed {
      logic        start;
      logic        free;
      logic [16:0] size;
   } hdr_type;
endpackage

[rtl/ffha_header_ram.sv]
// ----------------------------------------------------------------------------
// ffha_header_ram
// Per-unit block header store: start bit, free bit, payload size.
// One write and one registered read per cycle; clearing sweep after reset.
// ----------------------------------------------------------------------------
module ffha_header_ram #(
   parameter int HEAP_UNITS   = ffha_pkg::HEAP_UNITS_DEF,
   parameter int HEADER_UNITS = ffha_pkg::HEADER_UNITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ffha_pkg::mem_req_type req,
   output ffha_pkg::hdr_type     rd_data,
   output logic                  init_done
);
   import ffha_pkg::*;
   localparam int AW = $clog2(HEAP_UNITS);

   logic [18:0]   mem [HEAP_UNITS];
   logic [AW:0]   clr_ff, clr_in;
   hdr_type       rd_ff;
   logic [18:0]   wdata;
   logic [AW-1:0] waddr;
   logic          wen;

   assign init_done = clr_ff[AW];
   assign clr_in = init_done ? clr_ff : clr_ff + 1'b1;

   always_comb begin
      if (!init_done) begin
         wen   = 1'b1;
         waddr = clr_ff[AW-1:0];
         if (clr_ff[AW-1:0] == '0)
            wdata = {1'b1, 1'b1, 17'(HEAP_UNITS - HEADER_UNITS)};
         else
            wdata = '0;
      end else begin
         wen   = req.wr_en;
         waddr = req.wr_addr[AW-1:0];
         wdata = {req.wr_start, req.wr_free, req.wr_size};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) clr_ff <= '0;
      else clr_ff <= clr_in;
   end

   always_ff @(posedge clock) begin
      if (wen) mem[waddr] <= wdata;
      if (req.rd_en) rd_ff <= mem[req.rd_addr[AW-1:0]];
   end

   assign rd_data = rd_ff;
endmodule

[rtl/ffha_sequencer.sv]
// ----------------------------------------------------------------------------
// ffha_sequencer
// Walks headers for allocate and coalesce; handles free and query lookups.
// ----------------------------------------------------------------------------
module ffha_sequencer #(
   parameter int HEAP_UNITS   = ffha_pkg::HEAP_UNITS_DEF,
   parameter int HEADER_UNITS = ffha_pkg::HEADER_UNITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  init_done,
   input  logic                  cmd_valid,
   output logic                  cmd_ready,
   input  ffha_pkg::op_type      cmd_op,
   input  logic [10:0]           cmd_size,
   input  logic [9:0]            cmd_addr,
   output logic                  res_valid,
   input  logic                  res_ready,
   output logic [1:0]            res_status,
   output logic [9:0]            res_granted,
   output logic [10:0]           res_bsize,
   output logic [10:0]           res_used,
   output logic [31:0]           res_total,
   output ffha_pkg::mem_req_type mreq,
   input  ffha_pkg::hdr_type     rd
);
   import ffha_pkg::*;
   localparam logic [17:0] HEAP = 18'(HEAP_UNITS);
   localparam logic [17:0] HDR  = 18'(HEADER_UNITS);

   typedef enum logic [3:0] {
      S_IDLE, S_AREAD, S_AWAIT, S_FREAD, S_FWAIT,
      S_CREAD, S_CWAIT, S_NREAD, S_NWAIT, S_DONE
   } state_type;

   state_type   state_ff;
   op_type      op_ff;
   logic [10:0] size_ff;
   logic [17:0] pos_ff, nxt_ff;
   logic [16:0] psize_ff;
   logic [10:0] used_ff;
   logic [31:0] total_ff;
   logic [1:0]  status_ff;
   logic [9:0]  granted_ff;
   logic [10:0] bsize_ff;
   logic        res_valid_ff;

   logic [17:0] hdr_addr;
   logic        addr_ok;
   logic [17:0] next_pos;
   logic [32:0] tot_sum;

   assign hdr_addr = 18'(cmd_addr) - HDR;
   assign addr_ok  = (18'(cmd_addr) >= HDR) && (hdr_addr < HEAP);
   assign next_pos = pos_ff + HDR + 18'(rd.size);
   assign tot_sum  = 33'(total_ff) + 33'(cmd_size);

   assign cmd_ready  = (state_ff == S_IDLE) && init_done && !res_valid_ff;
   assign res_valid  = res_valid_ff;
   assign res_status = status_ff;
   assign res_granted = granted_ff;
   assign res_bsize  = bsize_ff;
   assign res_used   = used_ff;
   assign res_total  = total_ff;

   always_comb begin
      mreq = '0;
      case (state_ff)
         S_IDLE: begin
            mreq.rd_en   = cmd_valid && cmd_ready;
            mreq.rd_addr = 16'(hdr_addr);
         end
         S_AREAD, S_CREAD: begin
            mreq.rd_en = 1'b1;
            mreq.rd_addr = 16'(pos_ff);
         end
         S_NREAD: begin
            mreq.rd_en = 1'b1;
            mreq.rd_addr = 16'(nxt_ff);
         end
         S_AWAIT: begin
            if (rd.free && 18'(rd.size) == 18'(size_ff)) begin
               mreq.wr_en = 1'b1; mreq.wr_addr = 16'(pos_ff);
               mreq.wr_start = 1'b1; mreq.wr_size = rd.size;
            end else if (rd.free && 18'(rd.size) > 18'(size_ff) + HDR) begin
               // tail header; head written in S_DONE path below
               mreq.wr_en = 1'b1;
               mreq.wr_addr = 16'(pos_ff + HDR + 18'(size_ff));
               mreq.wr_start = 1'b1; mreq.wr_free = 1'b1;
               mreq.wr_size = 17'(18'(rd.size) - 18'(size_ff) - HDR);
            end
         end
         S_FWAIT: begin
            if (op_ff == OP_FREE && rd.start && !rd.free) begin
               mreq.wr_en = 1'b1; mreq.wr_addr = 16'(pos_ff);
               mreq.wr_start = 1'b1; mreq.wr_free = 1'b1;
               mreq.wr_size = rd.size;
            end
         end
         S_NWAIT: begin
            if (rd.free) begin
               mreq.wr_en = 1'b1; mreq.wr_addr = 16'(nxt_ff);
            end
         end
         S_DONE: begin
            // head rewrite after split or coalesce
            if (op_ff == OP_ALLOC || op_ff == OP_FREE) begin
               mreq.wr_en = 1'b1; mreq.wr_addr = 16'(pos_ff);
               mreq.wr_start = 1'b1; mreq.wr_free = (op_ff == OP_FREE);
               mreq.wr_size = psize_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         res_valid_ff <= 1'b0;
         used_ff <= '0;
         total_ff <= '0;
      end else begin
         if (res_valid_ff && res_ready) res_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: if (cmd_valid && cmd_ready) begin
               op_ff <= cmd_op; size_ff <= cmd_size;
               status_ff <= ST_OK; granted_ff <= '0; bsize_ff <= '0;
               pos_ff <= '0;
               case (cmd_op)
                  OP_ALLOC: begin
                     total_ff <= tot_sum[32] ? '1 : tot_sum[31:0];
                     state_ff <= S_AREAD;
                  end
                  OP_FREE, OP_QUERY: begin
                     pos_ff <= hdr_addr;
                     if (addr_ok) state_ff <= S_FWAIT;
                     else begin
                        status_ff <= ST_NO_BLOCK; res_valid_ff <= 1'b1;
                     end
                  end
                  default: res_valid_ff <= 1'b1;
               endcase
            end
            S_AREAD: begin
               if (pos_ff < HEAP) state_ff <= S_AWAIT;
               else begin
                  status_ff <= ST_NO_FIT; res_valid_ff <= 1'b1;
                  state_ff <= S_IDLE;
               end
            end
            S_AWAIT: begin
               if (rd.free && 18'(rd.size) == 18'(size_ff)) begin
                  granted_ff <= 10'(pos_ff + HDR);
                  used_ff <= used_ff + size_ff;
                  res_valid_ff <= 1'b1; state_ff <= S_IDLE;
               end else if (rd.free && 18'(rd.size) > 18'(size_ff) + HDR) begin
                  granted_ff <= 10'(pos_ff + HDR);
                  used_ff <= used_ff + size_ff;
                  psize_ff <= 17'(size_ff);
                  state_ff <= S_DONE;
               end else begin
                  pos_ff <= next_pos; state_ff <= S_AREAD;
               end
            end
            S_FWAIT: begin
               if (!rd.start) begin
                  status_ff <= ST_NO_BLOCK; res_valid_ff <= 1'b1;
                  state_ff <= S_IDLE;
               end else if (op_ff == OP_QUERY) begin
                  bsize_ff <= 11'(rd.size); res_valid_ff <= 1'b1;
                  state_ff <= S_IDLE;
               end else if (rd.free) begin
                  res_valid_ff <= 1'b1; state_ff <= S_IDLE;
               end else begin
                  used_ff <= used_ff - 11'(rd.size);
                  pos_ff <= '0; state_ff <= S_CREAD;
               end
            end
            S_CREAD: begin
               if (pos_ff < HEAP) state_ff <= S_CWAIT;
               else begin res_valid_ff <= 1'b1; state_ff <= S_IDLE; end
            end
            S_CWAIT: begin
               psize_ff <= rd.size;
               nxt_ff <= next_pos;
               if (rd.free && next_pos < HEAP) state_ff <= S_NREAD;
               else begin pos_ff <= next_pos; state_ff <= S_CREAD; end
            end
            S_NREAD: state_ff <= S_NWAIT;
            S_NWAIT: begin
               if (rd.free) begin
                  // absorb the neighbour, then try the one after it
                  psize_ff <= 17'(18'(psize_ff) + HDR + 18'(rd.size));
                  nxt_ff <= nxt_ff + HDR + 18'(rd.size);
                  if (nxt_ff + HDR + 18'(rd.size) < HEAP) state_ff <= S_NREAD;
                  else state_ff <= S_DONE;
               end else begin
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               if (op_ff == OP_ALLOC) begin
                  res_valid_ff <= 1'b1; state_ff <= S_IDLE;
               end else begin
                  pos_ff <= nxt_ff; state_ff <= S_CREAD;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

[rtl/first_fit_heap_allocator.sv]
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit allocator over a unit-addressed heap with coalescing on free.
// ----------------------------------------------------------------------------
// channel  direction  content
// req      in         operation, alloc_size, block_address
// rsp      out        status, granted_address, block_size, units_in_use,
//                     total_requested
//
// One item at a time; a stalled result blocks the next item. An out-of-range
// address or unknown operation is answered at acceptance; a query, double free
// or non-block address after one header read; allocate reads one header per
// block walked, plus a head rewrite for a split or a bound check for a failed
// walk; free then walks every block, reading free neighbours and rewriting
// merged heads. After reset all headers are initialised before req_tready rises.
module first_fit_heap_allocator #(
   parameter int HEAP_UNITS   = ffha_pkg::HEAP_UNITS_DEF,
   parameter int HEADER_UNITS = ffha_pkg::HEADER_UNITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // operation[1:0], alloc_size[12:2], block_address[22:13]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata   // status, granted_address, block_size,
                                   // units_in_use, total_requested
);
   import ffha_pkg::*;
   `include "assert_macros.svh"

   mem_req_type mreq;
   hdr_type     rd;
   logic        init_done;
   logic [1:0]  st;
   logic [9:0]  gr;
   logic [10:0] bs, uu;
   logic [31:0] tt;

   ffha_header_ram #(.HEAP_UNITS(HEAP_UNITS), .HEADER_UNITS(HEADER_UNITS)) u_ram (
      .clock, .reset, .req(mreq), .rd_data(rd), .init_done
   );

   ffha_sequencer #(.HEAP_UNITS(HEAP_UNITS), .HEADER_UNITS(HEADER_UNITS)) u_seq (
      .clock, .reset, .init_done,
      .cmd_valid(req_tvalid), .cmd_ready(req_tready),
      .cmd_op(op_type'(req_tdata[1:0])), .cmd_size(req_tdata[12:2]),
      .cmd_addr(req_tdata[22:13]),
      .res_valid(rsp_tvalid), .res_ready(rsp_tready),
      .res_status(st), .res_granted(gr), .res_bsize(bs), .res_used(uu),
      .res_total(tt), .mreq, .rd
   );

   assign rsp_tdata = {6'd0, tt, uu, bs, gr, st};

   `ASSERT_IMPLIES(a_no_accept_busy, clock, reset, rsp_tvalid, !req_tready)
   `ASSERT_IMPLIES(a_init_gate, clock, reset, !init_done, !req_tready)
   `ASSERT_NEXT(a_accept_busy, clock, reset, req_tvalid && req_tready, !req_tready)
endmodule

[tb/ffha_checker.sv]
// ----------------------------------------------------------------------------
// ffha_checker
// Watches the request and response streams of the heap allocator, keeps its
// own copy of the heap, predicts every response and compares field by field.
// ----------------------------------------------------------------------------
module ffha_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [23:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [71:0] rsp_tdata,
   output int          fail_count,
   output int          pending_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import ffha_pkg::*;

   localparam int HEAP = HEAP_UNITS_DEF;
   localparam int HDR  = HEADER_UNITS_DEF;

   typedef struct packed {
      logic [31:0] total;
      logic [10:0] in_use;
      logic [10:0] size;
      logic [9:0]  granted;
      logic [1:0]  status;
   } rsp_item_type;

   int unsigned   unit_size[HEAP];
   bit            heap_start[HEAP];
   bit            heap_free[HEAP];
   int unsigned   in_use;
   int unsigned   total_req;
   rsp_item_type  expected_rsps[$];

   function automatic void heap_clear();
      for (int i = 0; i < HEAP; i++) begin
         unit_size[i] = 0;
         heap_start[i] = 0;
         heap_free[i] = 0;
      end
      heap_start[0] = 1;
      heap_free[0] = 1;
      unit_size[0] = HEAP - HDR;
      in_use = 0;
      total_req = 0;
   endfunction

   function automatic void merge_free_runs();
      int unsigned p;
      int unsigned n;
      p = 0;
      while (p < HEAP) begin
         n = p + HDR + unit_size[p];
         if (n < HEAP && heap_free[p] && heap_free[n]) begin
            unit_size[p] += HDR + unit_size[n];
            heap_start[n] = 0;
            heap_free[n] = 0;
            unit_size[n] = 0;
         end else begin
            p = n;
         end
      end
   endfunction

   function automatic rsp_item_type predict_rsp(logic [23:0] d);
      rsp_item_type r;
      op_type       op;
      int unsigned  req;
      int unsigned  addr;
      int unsigned  p;
      int unsigned  sz;
      int unsigned  t;
      bit           found;
      op = op_type'(d[1:0]);
      req = 32'(d[12:2]);
      addr = 32'(d[22:13]);
      r = '0;
      if (op == OP_ALLOC) begin
         if (total_req > 32'hFFFF_FFFF - req) total_req = 32'hFFFF_FFFF;
         else total_req += req;
         found = 0;
         p = 0;
         while (p < HEAP && !found) begin
            sz = unit_size[p];
            if (heap_free[p] && sz == req) begin
               heap_free[p] = 0;
               found = 1;
            end else if (heap_free[p] && sz > req + HDR) begin
               t = p + HDR + req;
               heap_start[t] = 1;
               heap_free[t] = 1;
               unit_size[t] = sz - req - HDR;
               unit_size[p] = req;
               heap_free[p] = 0;
               found = 1;
            end else begin
               p += HDR + sz;
            end
         end
         if (found) begin
            r.granted = 10'(p + HDR);
            in_use += req;
         end else begin
            r.status = ST_NO_FIT;
         end
      end else if (op == OP_FREE || op == OP_QUERY) begin
         if (addr < HDR || addr - HDR >= HEAP || !heap_start[addr - HDR]) begin
            r.status = ST_NO_BLOCK;
         end else if (op == OP_QUERY) begin
            r.size = 11'(unit_size[addr - HDR]);
         end else if (!heap_free[addr - HDR]) begin
            heap_free[addr - HDR] = 1;
            in_use -= unit_size[addr - HDR];
            merge_free_runs();
         end
      end
      r.in_use = 11'(in_use);
      r.total = total_req;
      return r;
   endfunction

   always_ff @(posedge clock) begin
      rsp_item_type got;
      rsp_item_type want;
      if (reset) begin
         heap_clear();
         expected_rsps.delete();
         fail_count <= 0;
      end else begin
         if (req_tvalid && req_tready) expected_rsps.push_back(predict_rsp(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[65:0];
            if (expected_rsps.size() == 0) begin
               $error("response with nothing outstanding: %h", rsp_tdata);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_rsps.pop_front();
               if (got != want) begin
                  if (got.status != want.status)
                     $error("status: expected %0d actual %0d", want.status, got.status);
                  if (got.granted != want.granted)
                     $error("granted_address: expected %0d actual %0d",
                            want.granted, got.granted);
                  if (got.size != want.size)
                     $error("block_size: expected %0d actual %0d", want.size, got.size);
                  if (got.in_use != want.in_use)
                     $error("units_in_use: expected %0d actual %0d",
                            want.in_use, got.in_use);
                  if (got.total != want.total)
                     $error("total_requested: expected %0d actual %0d",
                            want.total, got.total);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

   assign pending_count = expected_rsps.size();
endmodule

[tb/tb_first_fit_heap_allocator.sv]
// ----------------------------------------------------------------------------
// tb_first_fit_heap_allocator
// Drives directed and random allocate/free/query/nop items into the allocator
// with random idling on both sides; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_first_fit_heap_allocator;
   import ffha_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG = 200000;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [71:0] rsp_tdata;
   int          fail_count;
   int          pending_count;
   int          send_idle_pct = 35;
   int          recv_idle_pct = 59;
   bit          hold_off = 0;
   int          idle_cycles = 0;
   bit          timed_out = 0;
   logic [9:0]  granted_list[$];

   always #4 clock = ~clock;

   first_fit_heap_allocator i_dut (.*);

   ffha_checker i_checker (.*);

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (!reset && idle_cycles > WATCHDOG && !timed_out) begin
         timed_out = 1;
         $display("*** FAILED ***");
         $finish;
      end
      // remember granted addresses so that frees and queries can target real blocks
      if (rsp_tvalid && rsp_tready && rsp_tdata[1:0] == ST_OK && rsp_tdata[11:2] != 0) begin
         granted_list.push_back(rsp_tdata[11:2]);
         if (granted_list.size() > 64) void'(granted_list.pop_front());
      end
   end

   always @(negedge clock) begin
      rsp_tready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
   end

   // returns at the falling edge after acceptance with tvalid still high;
   // the next call or drain() drops it
   task automatic send_item(op_type op, int unsigned sz, int unsigned addr);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 0;
         @(negedge clock);
      end
      req_tdata <= {1'b0, addr[9:0], sz[10:0], op};
      req_tvalid <= 1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_random();
      int unsigned k;
      int unsigned sz;
      int unsigned addr;
      k = $urandom_range(99);
      sz = ($urandom_range(19) == 0) ? $urandom_range(2047) : $urandom_range(40);
      addr = $urandom_range(1023);
      if (granted_list.size() > 0 && $urandom_range(9) < 8)
         addr = 32'(granted_list[$urandom_range(granted_list.size() - 1)]);
      if (k < 45) send_item(OP_ALLOC, sz, addr);
      else if (k < 80) send_item(OP_FREE, sz, addr);
      else if (k < 97) send_item(OP_QUERY, sz, addr);
      else send_item(OP_NOP, sz, addr);
   endtask

   task automatic drain();
      req_tvalid <= 0;
      while (pending_count != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      @(negedge clock);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      // directed: extremes and special cases
      send_item(OP_QUERY, 0, 1);
      send_item(OP_QUERY, 0, 0);
      send_item(OP_FREE, 0, 0);
      send_item(OP_ALLOC, 2047, 0);
      send_item(OP_ALLOC, 1024, 0);
      send_item(OP_ALLOC, 0, 1023);
      send_item(OP_ALLOC, 5, 0);
      send_item(OP_QUERY, 0, 2);
      send_item(OP_QUERY, 0, 1023);
      send_item(OP_FREE, 0, 3);
      send_item(OP_FREE, 0, 2);
      send_item(OP_FREE, 0, 2);
      send_item(OP_FREE, 0, 1);
      send_item(OP_NOP, 2047, 1023);
      send_item(OP_ALLOC, 1022, 0);
      send_item(OP_ALLOC, 1, 0);
      send_item(OP_FREE, 0, 1);
      send_item(OP_ALLOC, 1023, 0);
      send_item(OP_ALLOC, 0, 0);
      send_item(OP_FREE, 0, 1);
      send_item(OP_ALLOC, 1023, 0);
      send_item(OP_FREE, 0, 1);
      drain();
      // long receiver hold-off while requests keep coming
      hold_off = 1;
      fork
         repeat (300) @(posedge clock);
         repeat (6) send_random();
      join_any
      hold_off = 0;
      wait fork;
      for (int i = 0; i < 360; i++) send_random();
      send_idle_pct = 59;
      recv_idle_pct = 35;
      for (int i = 0; i < 360; i++) send_random();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      for (int i = 0; i < 360; i++) send_random();
      drain();
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule

[files.f]
+incdir+rtl
rtl/ffha_pkg.sv
rtl/ffha_header_ram.sv
rtl/ffha_sequencer.sv
rtl/first_fit_heap_allocator.sv
tb/ffha_checker.sv
tb/tb_first_fit_heap_allocator.sv
